// ----- rtl/bpfa_pkg.sv -----
package bpfa_pkg;

    localparam int MAX_FRAME_COUNT_DEF = 32768;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam logic [15:0] FM_RESET = 16'd4096;
    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef enum logic [3:0] {
        OP_ALLOC_ONE   = 4'd0,
        OP_ALLOC_RUN   = 4'd1,
        OP_FREE_ONE    = 4'd2,
        OP_FREE_RUN    = 4'd3,
        OP_QUERY       = 4'd4,
        OP_MARK_ONE    = 4'd5,
        OP_REGION_USED = 4'd6,
        OP_REGION_FREE = 4'd7,
        OP_STATS       = 4'd8,
        OP_INIT        = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_FETCH,
        ST_BIT,
        ST_WRITE,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WM_QUERY,
        WM_SCAN_ONE,
        WM_SCAN_RUN,
        WM_TAKE,
        WM_GIVE
    } walk_mode_t;

    typedef enum logic [1:0] {
        SN_DONE,
        SN_WALK,
        SN_FILL
    } setup_next_t;

    typedef enum logic [1:0] {
        BN_BIT,
        BN_LOAD,
        BN_WRITE,
        BN_DONE
    } bit_next_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic load;
        logic fetch;
        logic bit_step;
        logic write;
        logic fill;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        setup_next_t setup_next;
        logic        skip;
        logic        skip_end;
        bit_next_t   bit_next;
        logic        more;
        logic        fill_last;
    } status_t;

endpackage

// ----- rtl/bpfa_ram.sv -----
module bpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bpfa_ctrl.sv -----
module bpfa_ctrl import bpfa_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (status.setup_next)
                    SN_WALK: state_next = ST_LOAD;
                    SN_FILL: state_next = ST_FILL;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_LOAD:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (status.skip)
                begin
                    state_next = status.skip_end ? ST_DONE : ST_LOAD;
                end
                else
                begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                case (status.bit_next)
                    BN_LOAD:  state_next = ST_LOAD;
                    BN_WRITE: state_next = ST_WRITE;
                    BN_DONE:  state_next = ST_DONE;
                    default:  state_next = ST_BIT;
                endcase
            end
            ST_WRITE:
            begin
                state_next = status.more ? ST_LOAD : ST_DONE;
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.fetch    = (state_reg == ST_FETCH);
        cmd.bit_step = (state_reg == ST_BIT);
        cmd.write    = (state_reg == ST_WRITE);
        cmd.fill     = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
        s_tready     = (state_reg == ST_IDLE);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- rtl/bpfa_datapath.sv -----
module bpfa_datapath import bpfa_pkg::*; #(
    parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic [3:0]  in_op,
    input  logic [31:0] in_address,
    input  logic [15:0] in_frame_count,
    input  logic [31:0] in_byte_length,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [31:0] result_address,
    output logic        found,
    output logic        is_allocated,
    output logic [15:0] used_total,
    output logic [15:0] free_total
);

    localparam int DEPTH = (MAX_FRAME_COUNT + 7) / 8;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = 33 - PAGE_SHIFT;
    localparam logic [31:0] PMASK = 32'((1 << PAGE_SHIFT) - 1);
    localparam logic [15:0] USED_RESET =
        (32'(FM_RESET) > 32'(MAX_FRAME_COUNT)) ? 16'(MAX_FRAME_COUNT) : FM_RESET;

    logic [15:0]   fm_reg;
    logic [15:0]   used_reg;
    logic [AW-1:0] fill_reg;
    walk_mode_t    mode_reg;

    op_t           op_reg;
    logic [31:0]   address_reg;
    logic [15:0]   count_reg;
    logic [31:0]   length_reg;
    logic [FW-1:0] cur_reg;
    logic [FW-1:0] end_reg;
    logic [15:0]   run_reg;
    logic [15:0]   start_reg;
    logic [7:0]    word_reg;
    logic [AW-1:0] baddr_reg;
    logic [15:0]   res_frame_reg;
    logic          found_reg;
    logic          alloc_reg;

    logic [7:0]    ram_rdata;
    logic [15:0]   tf;
    logic [FW-1:0] tf_w;
    logic [FW-1:0] frame;
    logic [31:0]   sum;
    logic [31:0]   up_sum;
    logic [31:0]   up_addr;
    logic [FW-1:0] first_raw;
    logic [FW-1:0] end_raw;
    logic [FW-1:0] end_eff;
    walk_mode_t    mode_sel;
    logic          walk_ok;
    logic          b;
    logic [FW-1:0] cur_inc;
    logic          last;
    logic          boundary;
    logic [16:0]   run_inc;
    logic          run_hit;
    logic [15:0]   start_sel;
    logic [7:0]    word_set;
    logic [7:0]    word_clr;
    logic [FW-1:0] next_byte;
    logic [15:0]   used_inc;
    logic [15:0]   used_dec;

    bpfa_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write || cmd.fill),
        .waddr (cmd.fill ? fill_reg : baddr_reg),
        .wdata (cmd.fill ? FULL_BYTE : word_reg),
        .re    (cmd.load),
        .raddr (AW'(cur_reg >> 3)),
        .rdata (ram_rdata)
    );

    assign tf = ({16'd0, fm_reg} > 32'(MAX_FRAME_COUNT)) ? 16'(MAX_FRAME_COUNT) : fm_reg;
    assign tf_w = FW'(tf);
    assign frame = FW'(address_reg >> PAGE_SHIFT);
    assign sum = address_reg + length_reg;
    assign up_sum = sum + PMASK;
    assign up_addr = address_reg + PMASK;
    assign used_inc = (used_reg != 16'hFFFF) ? used_reg + 16'd1 : used_reg;
    assign used_dec = (used_reg != 16'd0) ? used_reg - 16'd1 : used_reg;

    always_comb
    begin
        first_raw = frame;
        end_raw   = frame + FW'(1);
        mode_sel  = WM_QUERY;
        case (op_reg)
            OP_ALLOC_ONE:
            begin
                first_raw = '0;
                end_raw   = tf_w;
                mode_sel  = WM_SCAN_ONE;
            end
            OP_ALLOC_RUN:
            begin
                first_raw = '0;
                end_raw   = tf_w;
                mode_sel  = WM_SCAN_RUN;
            end
            OP_FREE_ONE:
            begin
                mode_sel = WM_GIVE;
            end
            OP_FREE_RUN:
            begin
                end_raw  = frame + FW'(count_reg);
                mode_sel = WM_GIVE;
            end
            OP_MARK_ONE:
            begin
                mode_sel = WM_TAKE;
            end
            OP_REGION_USED:
            begin
                end_raw  = FW'(up_sum >> PAGE_SHIFT);
                mode_sel = WM_TAKE;
            end
            OP_REGION_FREE:
            begin
                first_raw = FW'(up_addr >> PAGE_SHIFT);
                end_raw   = FW'(sum >> PAGE_SHIFT);
                mode_sel  = WM_GIVE;
            end
            default:
            begin
                mode_sel = WM_QUERY;
            end
        endcase
        end_eff = (end_raw < tf_w) ? end_raw : tf_w;
        walk_ok = (first_raw < end_eff) && !((op_reg == OP_ALLOC_RUN) && (count_reg == 16'd0));
    end

    always_comb
    begin
        b         = word_reg[cur_reg[2:0]];
        cur_inc   = cur_reg + FW'(1);
        last      = (cur_inc >= end_reg);
        boundary  = &cur_reg[2:0];
        run_inc   = {1'b0, run_reg} + 17'd1;
        run_hit   = (run_inc >= {1'b0, count_reg});
        start_sel = (run_reg == 16'd0) ? cur_reg[15:0] : start_reg;
        word_set  = word_reg | (8'd1 << cur_reg[2:0]);
        word_clr  = word_reg & ~(8'd1 << cur_reg[2:0]);
        next_byte = {cur_reg[FW-1:3] + 1'b1, 3'b000};

        status = '0;
        case (op_reg)
            OP_INIT: status.setup_next = SN_FILL;
            OP_ALLOC_ONE, OP_ALLOC_RUN, OP_FREE_ONE, OP_FREE_RUN, OP_QUERY,
            OP_MARK_ONE, OP_REGION_USED, OP_REGION_FREE:
                status.setup_next = walk_ok ? SN_WALK : SN_DONE;
            default: status.setup_next = SN_DONE;
        endcase
        status.skip = ((mode_reg == WM_SCAN_ONE) || (mode_reg == WM_SCAN_RUN))
                      && (ram_rdata == FULL_BYTE);
        status.skip_end = (next_byte >= end_reg);
        case (mode_reg)
            WM_QUERY:
            begin
                status.bit_next = BN_DONE;
            end
            WM_SCAN_ONE:
            begin
                if (!b)
                begin
                    status.bit_next = BN_WRITE;
                end
                else if (last)
                begin
                    status.bit_next = BN_DONE;
                end
                else
                begin
                    status.bit_next = boundary ? BN_LOAD : BN_BIT;
                end
            end
            WM_SCAN_RUN:
            begin
                if (!b && run_hit)
                begin
                    status.bit_next = BN_LOAD;
                end
                else if (last)
                begin
                    status.bit_next = BN_DONE;
                end
                else
                begin
                    status.bit_next = boundary ? BN_LOAD : BN_BIT;
                end
            end
            default:
            begin
                status.bit_next = (last || boundary) ? BN_WRITE : BN_BIT;
            end
        endcase
        status.more = (mode_reg != WM_SCAN_ONE) && (cur_reg < end_reg);
        status.fill_last = (fill_reg == AW'(DEPTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_reg   <= FM_RESET;
            used_reg <= USED_RESET;
            fill_reg <= '0;
            mode_reg <= WM_QUERY;
        end
        else
        begin
            if (cfg_we)
            begin
                fm_reg <= cfg_wdata;
            end
            if (cmd.setup)
            begin
                mode_reg <= mode_sel;
                fill_reg <= '0;
                if (op_reg == OP_INIT)
                begin
                    used_reg <= tf;
                end
            end
            if (cmd.fill)
            begin
                fill_reg <= status.fill_last ? '0 : fill_reg + AW'(1);
            end
            if (cmd.bit_step)
            begin
                case (mode_reg)
                    WM_SCAN_ONE, WM_TAKE:
                    begin
                        if (!b)
                        begin
                            used_reg <= used_inc;
                        end
                    end
                    WM_GIVE:
                    begin
                        if (b)
                        begin
                            used_reg <= used_dec;
                        end
                    end
                    WM_SCAN_RUN:
                    begin
                        if (!b && run_hit)
                        begin
                            mode_reg <= WM_TAKE;
                        end
                    end
                    default:
                    begin
                        used_reg <= used_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op_t'(in_op);
            address_reg <= in_address;
            count_reg   <= in_frame_count;
            length_reg  <= in_byte_length;
        end
        if (cmd.setup)
        begin
            cur_reg       <= first_raw;
            end_reg       <= end_eff;
            run_reg       <= '0;
            res_frame_reg <= '0;
            found_reg     <= 1'b0;
            alloc_reg     <= (op_reg == OP_QUERY) && !walk_ok;
        end
        if (cmd.load)
        begin
            baddr_reg <= AW'(cur_reg >> 3);
        end
        if (cmd.fetch)
        begin
            if (status.skip)
            begin
                cur_reg <= next_byte;
                run_reg <= '0;
            end
            else
            begin
                word_reg <= ram_rdata;
            end
        end
        if (cmd.bit_step)
        begin
            case (mode_reg)
                WM_QUERY:
                begin
                    alloc_reg <= b;
                end
                WM_SCAN_ONE:
                begin
                    if (!b)
                    begin
                        word_reg      <= word_set;
                        res_frame_reg <= cur_reg[15:0];
                        found_reg     <= 1'b1;
                    end
                    else
                    begin
                        cur_reg <= cur_inc;
                    end
                end
                WM_SCAN_RUN:
                begin
                    if (!b)
                    begin
                        if (run_hit)
                        begin
                            cur_reg       <= FW'(start_sel);
                            end_reg       <= FW'(start_sel) + FW'(count_reg);
                            res_frame_reg <= start_sel;
                            found_reg     <= 1'b1;
                        end
                        else
                        begin
                            run_reg   <= run_inc[15:0];
                            start_reg <= start_sel;
                            cur_reg   <= cur_inc;
                        end
                    end
                    else
                    begin
                        run_reg <= '0;
                        cur_reg <= cur_inc;
                    end
                end
                WM_TAKE:
                begin
                    if (!b)
                    begin
                        word_reg <= word_set;
                    end
                    cur_reg <= cur_inc;
                end
                default:
                begin
                    if (b)
                    begin
                        word_reg <= word_clr;
                    end
                    cur_reg <= cur_inc;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            result_address <= 32'(res_frame_reg) << PAGE_SHIFT;
            found          <= found_reg;
            is_allocated   <= alloc_reg;
            used_total     <= used_reg;
            free_total     <= (tf > used_reg) ? tf - used_reg : 16'd0;
        end
    end

endmodule

// ----- rtl/bitmap_page_frame_allocator_top.sv -----
// channel  | group                        | width           | direction
// input    | s_tvalid s_tready s_tdata    | tdata 80, user 4 | in
//          | s_tuser                      |                  |
// result   | m_tvalid m_tready m_tdata    | tdata 72         | out
// config   | cfg_we cfg_wdata             | 16               | in
//
// after reset a clearing pass writes every bitmap byte, (MAX_FRAME_COUNT+7)/8 of them,
// 4096 at the defaults, to all ones with s_tready low
// one item at a time: accept, setup and done states plus the bitmap walk, which loads
// and fetches each visited byte, steps through its frames one at a time and writes it
// back through the bitmap ram write port for ops that change it; allocation scans skip
// full bytes; init sets every bitmap byte to all ones; a finished result waits in its output register
module bitmap_page_frame_allocator_top import bpfa_pkg::*; #(
    parameter int MAX_FRAME_COUNT = MAX_FRAME_COUNT_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // address, frame_count, byte_length
    input  logic [3:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // result_address, found, is_allocated, used_total,
                                   // free_total, zero pad
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    cmd_t        cmd;
    status_t     status;
    logic [31:0] result_address;
    logic        found;
    logic        is_allocated;
    logic [15:0] used_total;
    logic [15:0] free_total;

    bpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bpfa_datapath #(
        .MAX_FRAME_COUNT (MAX_FRAME_COUNT),
        .PAGE_SHIFT      (PAGE_SHIFT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_op          (s_tuser),
        .in_address     (s_tdata[31:0]),
        .in_frame_count (s_tdata[47:32]),
        .in_byte_length (s_tdata[79:48]),
        .cmd            (cmd),
        .status         (status),
        .result_address (result_address),
        .found          (found),
        .is_allocated   (is_allocated),
        .used_total     (used_total),
        .free_total     (free_total)
    );

    assign m_tdata = {6'd0, free_total, used_total, is_allocated, found, result_address};

endmodule

// ----- rtl/bpfa_checker.sv -----
module bpfa_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // held result beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // failed or non-alloc results carry address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero address without found");

    // an allocation never also answers a query
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> !m_tdata[33])
        else $error("found and is_allocated both set");

endmodule

bind bitmap_page_frame_allocator_top bpfa_sva u_bpfa_sva (.*);
